>>> src/triangle_vertex_dedup_indexer_defines.svh
// assertion macros for the vertex dedup indexer
`ifndef TRIANGLE_VERTEX_DEDUP_INDEXER_DEFINES_SVH
`define TRIANGLE_VERTEX_DEDUP_INDEXER_DEFINES_SVH

`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define TVDI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that an event is followed by a condition in the next cycle
`define TVDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TVDI_ASSERT(lbl, prop, msg)
`define TVDI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/tvdi_pkg.sv
`default_nettype none
package tvdi_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int IDX_OUT_W    = 12;
    localparam int CNT_OUT_W    = 13;

    // request classes
    localparam logic [1:0] OP_TRI   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_DEGEN = 2'd2;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vertex_t;

    localparam int VERT_W = $bits(vertex_t);

    typedef struct packed {
        logic [1:0]        op;
        vertex_t [2:0]     verts;
    } cmd_t;

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    // ieee equality: signed zeros match, nan matches nothing
    function automatic logic coord_eq(input logic [31:0] a, input logic [31:0] b);
        logic r;
        if (is_nan(a) || is_nan(b))
            r = 1'b0;
        else
            r = (a == b) || (((a | b) & 32'h7FFF_FFFF) == 32'd0);
        return r;
    endfunction

    function automatic logic vert_eq(input vertex_t p, input vertex_t q);
        return coord_eq(p.x, q.x) && coord_eq(p.y, q.y) && coord_eq(p.z, q.z);
    endfunction

endpackage
`default_nettype wire

>>> src/tvdi_ram.sv
`default_nettype none
module tvdi_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/tvdi_front.sv
`default_nettype none
module tvdi_front
    import tvdi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        kind,
    input  wire vertex_t [2:0] verts,
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  wire logic        q_take
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd_in;
    logic       accept;

    // classify the incoming request
    always_comb
    begin
        cmd_in.verts = verts;
        if (kind)
            cmd_in.op = OP_CLEAR;
        else if (vert_eq(verts[0], verts[1]) || vert_eq(verts[1], verts[2]) ||
                 vert_eq(verts[0], verts[2]))
            cmd_in.op = OP_DEGEN;
        else
            cmd_in.op = OP_TRI;
    end

    assign full    = (cnt_reg == 2'd2);
    assign accept  = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = ent_reg[rd_ptr_reg];

    // two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ accept;
        rd_ptr_next = rd_ptr_reg ^ (q_take && q_valid);
        cnt_next    = cnt_reg + 2'(accept) - 2'(q_take && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

>>> src/tvdi_back.sv
`default_nettype none
module tvdi_back
    import tvdi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire cmd_t                   q_cmd,
    output logic                        q_take,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [IDX_OUT_W-1:0]        index_a,
    output logic [IDX_OUT_W-1:0]        index_b,
    output logic [IDX_OUT_W-1:0]        index_c,
    output logic [2:0]                  new_mask,
    output logic                        dropped,
    output logic                        overflow,
    output logic [CNT_OUT_W-1:0]        vertex_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_APPEND = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]        state_reg, state_next;
    vertex_t [2:0]     verts_reg, verts_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] addr_d_reg, addr_d_next;
    logic [2:0]        hit_reg, hit_next;
    logic [ADDR_W-1:0] idx_reg [3];
    logic [ADDR_W-1:0] idx_next [3];
    logic [2:0]        mask_reg, mask_next;
    logic              drop_reg, drop_next;
    logic              ovf_reg, ovf_next;
    logic [1:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;

    logic              we;
    vertex_t           wdata;
    logic [ADDR_W-1:0] raddr;
    logic [VERT_W-1:0] rdata;
    logic [1:0]        need;

    tvdi_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign raddr = ptr_reg[ADDR_W-1:0];
    assign need  = 2'(!hit_next[0]) + 2'(!hit_next[1]) + 2'(!hit_next[2]);
    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || pop);

    // sequencer: scan the stored vertices, then append the misses; clears, degenerates and overflows go to the result
    always_comb
    begin
        state_next  = state_reg;
        verts_next  = verts_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pend_next   = 1'b0;
        addr_d_next = addr_d_reg;
        hit_next    = hit_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        drop_next   = drop_reg;
        ovf_next    = ovf_reg;
        step_next   = step_reg;
        q_take      = 1'b0;
        we          = 1'b0;
        wdata       = verts_reg[step_reg];
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take     = 1'b1;
                    verts_next = q_cmd.verts;
                    ptr_next   = '0;
                    hit_next   = 3'b000;
                    for (int k = 0; k < 3; k++)
                        idx_next[k] = '0;
                    mask_next  = 3'b000;
                    drop_next  = (q_cmd.op != OP_TRI);
                    ovf_next   = 1'b0;
                    if (q_cmd.op == OP_CLEAR)
                        count_next = '0;
                    state_next = (q_cmd.op == OP_TRI) ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN:
            begin
                // compare the entry read last cycle
                if (pend_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (!hit_reg[k] && vert_eq(vertex_t'(rdata), verts_reg[k]))
                        begin
                            hit_next[k] = 1'b1;
                            idx_next[k] = addr_d_reg;
                        end
                    end
                end
                if (ptr_reg < count_reg && hit_next != 3'b111)
                begin
                    pend_next   = 1'b1;
                    addr_d_next = ptr_reg[ADDR_W-1:0];
                    ptr_next    = ptr_reg + CNT_W'(1);
                end
                else if (!pend_reg || hit_next == 3'b111)
                begin
                    step_next = 2'd0;
                    if ({1'b0, count_reg} + (CNT_W+1)'(need) > (CNT_W+1)'(MAX_VERTICES))
                    begin
                        drop_next = 1'b1;
                        ovf_next  = 1'b1;
                        for (int k = 0; k < 3; k++)
                            idx_next[k] = '0;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                if (!hit_reg[step_reg])
                begin
                    we                  = 1'b1;
                    idx_next[step_reg]  = count_reg[ADDR_W-1:0];
                    mask_next[step_reg] = 1'b1;
                    count_next          = count_reg + CNT_W'(1);
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result slot handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    assign empty = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        verts_reg  <= verts_next;
        ptr_reg    <= ptr_next;
        addr_d_reg <= addr_d_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
        mask_reg   <= mask_next;
        drop_reg   <= drop_next;
        ovf_reg    <= ovf_next;
        step_reg   <= step_next;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            index_a      <= IDX_OUT_W'(idx_reg[0]);
            index_b      <= IDX_OUT_W'(idx_reg[1]);
            index_c      <= IDX_OUT_W'(idx_reg[2]);
            new_mask     <= mask_reg;
            dropped      <= drop_reg;
            overflow     <= ovf_reg;
            vertex_count <= CNT_OUT_W'(count_reg);
        end
    end

endmodule
`default_nettype wire

>>> src/triangle_vertex_dedup_indexer.sv
// Triangle vertex dedup indexer: each request is a triangle of three vertices
// (float bit patterns) or a clear. A front stage classifies requests (clear,
// degenerate, triangle) into a two-entry queue; a back stage looks each
// triangle's vertices up by a linear scan of the vertex memory, one stored
// entry per cycle with all three vertices compared at once (the scan stops
// early once all three have matched), then appends the misses one per cycle.
// A clear or degenerate triangle skips the lookup and goes straight to the
// result, and a triangle whose misses would overflow the table is dropped
// without appending. The vertex memory needs no clearing after reset: only
// entries below the stored count are read.
`default_nettype none
`include "triangle_vertex_dedup_indexer_defines.svh"
module triangle_vertex_dedup_indexer
    import tvdi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 kind,
    input  wire logic [31:0]          v0_x,
    input  wire logic [31:0]          v0_y,
    input  wire logic [31:0]          v0_z,
    input  wire logic [31:0]          v1_x,
    input  wire logic [31:0]          v1_y,
    input  wire logic [31:0]          v1_z,
    input  wire logic [31:0]          v2_x,
    input  wire logic [31:0]          v2_y,
    input  wire logic [31:0]          v2_z,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [IDX_OUT_W-1:0]      index_a,
    output logic [IDX_OUT_W-1:0]      index_b,
    output logic [IDX_OUT_W-1:0]      index_c,
    output logic [2:0]                new_mask,
    output logic                      dropped,
    output logic                      overflow,
    output logic [CNT_OUT_W-1:0]      vertex_count
);

    vertex_t [2:0] verts;
    logic          q_valid;
    cmd_t          q_cmd;
    logic          q_take;

    assign verts[0] = '{x: v0_x, y: v0_y, z: v0_z};
    assign verts[1] = '{x: v1_x, y: v1_y, z: v1_z};
    assign verts[2] = '{x: v2_x, y: v2_y, z: v2_z};

    // request classification and queue
    tvdi_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .kind    (kind),
        .verts   (verts),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_take  (q_take)
    );

    // lookup, append and result
    tvdi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_take       (q_take),
        .empty        (empty),
        .pop          (pop),
        .index_a      (index_a),
        .index_b      (index_b),
        .index_c      (index_c),
        .new_mask     (new_mask),
        .dropped      (dropped),
        .overflow     (overflow),
        .vertex_count (vertex_count)
    );

    // result consistency
    `TVDI_ASSERT(a_ovf_drops, (!empty && overflow) |-> dropped, "overflow without drop")
    `TVDI_ASSERT(a_mask_kept, (!empty && new_mask != 3'b000) |-> !dropped, "new vertices on drop")
    `TVDI_ASSERT(a_kept_count, (!empty && !dropped && MAX_VERTICES < 8192) |-> vertex_count != '0, "kept triangle with empty table")
    `TVDI_ASSERT_NEXT(a_pop_frees, (pop && !empty && q_valid == 1'b0 && full == 1'b0 && !push), 1'b1, "pop handshake")

endmodule
`default_nettype wire
